### rtl/ptc_pkg.sv
// Package for the pressure/temperature compensation block.
// Holds field widths, calibration register codes, fixed-point constants and
// the pipeline control struct. No dependencies.
package ptc_pkg;

  // Field widths of the input and result beats.
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 20;
  localparam int PRESS_W = 22;

  // Configuration port.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1_SENS     = 3'd0,
    REG_C2_OFFSET   = 3'd1,
    REG_C3_TCS      = 3'd2,
    REG_C4_TCO      = 3'd3,
    REG_C5_TREF     = 3'd4,
    REG_C6_TEMPSENS = 3'd5
  } cfg_reg_t;

  // Pipeline depth: one register stage per entry.
  localparam int PTC_STAGES = 12;

  // Fixed-point constants.
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
  localparam logic [16:0]              TI_MAX    = 17'd98304;
  localparam logic [PRESS_W-1:0]       P_MAX     = 22'h3FFFFF;
  // Pressure beyond the range once divided by ten: 10 * 2^22.
  localparam logic [25:0]              P_SAT_Z   = 26'd41943040;
  // ceil(2^30 / 10); exact quotient for any 26-bit dividend.
  localparam logic [26:0]              RECIP10   = 27'd107374183;

  // Per-stage load enables and valid flags from the pipeline controller.
  typedef struct packed {
    logic [PTC_STAGES-1:0] en;
    logic [PTC_STAGES-1:0] valid;
  } ptc_pipe_t;

endpackage

### rtl/ptc_if.sv
// Handshake channels of the compensation block: raw samples in, results out.
// Depends on ptc_pkg for the field widths.
interface ptc_sample_if import ptc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface ptc_result_if import ptc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [PRESS_W-1:0]       pressure_value;

  modport source (output valid, temperature_centi, pressure_value, input ready);
  modport sink   (input valid, temperature_centi, pressure_value, output ready);
endinterface

### rtl/ptc_pipe_ctrl.sv
// Valid/ready control for the compensation pipeline.
// Each stage loads when it is empty or when the stage after it moves on,
// so bubbles collapse and a stalled output holds the full stages ahead of any gap.
// Depends on ptc_pkg.
module ptc_pipe_ctrl import ptc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output ptc_pipe_t pipe
);

  localparam int LAST = PTC_STAGES - 1;

  logic [PTC_STAGES-1:0] valid;
  logic [PTC_STAGES-1:0] valid_next;
  logic [PTC_STAGES-1:0] en;

  // Load enables ripple back from the output.
  always_comb begin
    en[LAST] = !valid[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  // Valid flags follow the data one stage per load.
  always_comb begin
    for (int k = 0; k < PTC_STAGES; k++) begin
      if (!en[k]) begin
        valid_next[k] = valid[k];
      end else if (k == 0) begin
        valid_next[k] = in_valid;
      end else begin
        valid_next[k] = valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready   = en[0];
  assign pipe.en    = en;
  assign pipe.valid = valid;

endmodule

### rtl/pressure_temperature_compensation.sv
// Barometric pressure and temperature compensation with second-order correction.
// Each accepted sample beat passes through every pipeline stage to its result beat.
// Throughput: one beat per cycle; a stalled result holds the full stages ahead of any gap.
// Reset clears the six calibration words to zero and empties the pipeline.
// Depends on ptc_pkg, ptc_if and ptc_pipe_ctrl.
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_data,
  ptc_sample_if.sink           sample,
  ptc_result_if.source         result
);

  // Calibration words.
  logic [CAL_W-1:0] c1_sens;
  logic [CAL_W-1:0] c2_offset;
  logic [CAL_W-1:0] c3_tcs;
  logic [CAL_W-1:0] c4_tco;
  logic [CAL_W-1:0] c5_tref;
  logic [CAL_W-1:0] c6_tempsens;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_sens     <= '0;
      c2_offset   <= '0;
      c3_tcs      <= '0;
      c4_tco      <= '0;
      c5_tref     <= '0;
      c6_tempsens <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_C1_SENS:     c1_sens     <= cfg_data;
        REG_C2_OFFSET:   c2_offset   <= cfg_data;
        REG_C3_TCS:      c3_tcs      <= cfg_data;
        REG_C4_TCO:      c4_tco      <= cfg_data;
        REG_C5_TREF:     c5_tref     <= cfg_data;
        REG_C6_TEMPSENS: c6_tempsens <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  ptc_pipe_t pipe;

  ptc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_ready (result.ready),
    .pipe      (pipe)
  );

  // Stage 1: temperature difference dT = D2 - C5 * 256.
  logic [RAW_W-1:0] s1_d1;
  logic signed [24:0] s1_dt;

  always_ff @(posedge clk) begin
    if (pipe.en[0]) begin
      s1_d1 <= sample.raw_pressure;
      s1_dt <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5_tref, 8'b0});
    end
  end

  // Stage 2: the three first-order products and the square of dT.
  logic [RAW_W-1:0]   s2_d1;
  logic signed [41:0] s2_prod_t;
  logic signed [41:0] s2_prod_o;
  logic signed [41:0] s2_prod_s;
  logic [48:0]        s2_dt_sq;
  logic signed [49:0] dt_sq_full;

  assign dt_sq_full = s1_dt * s1_dt;

  always_ff @(posedge clk) begin
    if (pipe.en[1]) begin
      s2_d1     <= s1_d1;
      s2_prod_t <= s1_dt * $signed({1'b0, c6_tempsens});
      s2_prod_o <= s1_dt * $signed({1'b0, c4_tco});
      s2_prod_s <= s1_dt * $signed({1'b0, c3_tcs});
      s2_dt_sq  <= dt_sq_full[48:0];
    end
  end

  // Stage 3: truncating shifts give the temperature step, OFF and SENS;
  // the branch and the second-order temperature term follow from its sign.
  logic signed [41:0] t_sum;
  logic signed [41:0] t_quot;
  logic signed [41:0] o_sum;
  logic signed [41:0] o_quot;
  logic signed [41:0] s_sum;
  logic signed [41:0] s_quot;
  logic signed [17:0] q_next;
  logic [49:0]        dt_sq3;
  logic [16:0]        ti_next;

  assign t_sum  = s2_prod_t + (s2_prod_t[41] ? 42'sd8388607 : 42'sd0);
  assign t_quot = t_sum >>> 23;
  assign o_sum  = s2_prod_o + (s2_prod_o[41] ? 42'sd127 : 42'sd0);
  assign o_quot = o_sum >>> 7;
  assign s_sum  = s2_prod_s + (s2_prod_s[41] ? 42'sd255 : 42'sd0);
  assign s_quot = s_sum >>> 8;
  assign q_next = t_quot[17:0];
  assign dt_sq3 = {s2_dt_sq, 1'b0} + {1'b0, s2_dt_sq};
  // Cold branch: 3 * dT^2 / 2^33; warm branch: 2 * dT^2 / 2^37.
  assign ti_next = q_next[17] ? dt_sq3[49:33] : {4'b0, s2_dt_sq[48:36]};

  logic [RAW_W-1:0]   s3_d1;
  logic signed [17:0] s3_q;
  logic               s3_low;
  logic [16:0]        s3_ti;
  logic signed [34:0] s3_off;
  logic signed [33:0] s3_sens;

  always_ff @(posedge clk) begin
    if (pipe.en[2]) begin
      s3_d1   <= s2_d1;
      s3_q    <= q_next;
      s3_low  <= q_next[17];
      s3_ti   <= ti_next;
      s3_off  <= $signed({3'b0, c2_offset, 16'b0}) + $signed(o_quot[34:0]);
      s3_sens <= $signed({3'b0, c1_sens, 15'b0}) + $signed(s_quot[33:0]);
    end
  end

  // Stage 4: square of (2000 - TEMP) and the final temperature.
  logic signed [35:0] aux_full;

  assign aux_full = s3_q * s3_q;

  logic [RAW_W-1:0]         s4_d1;
  logic                     s4_low;
  logic [33:0]              s4_aux;
  logic signed [34:0]       s4_off;
  logic signed [33:0]       s4_sens;
  logic signed [TEMP_W-1:0] s4_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[3]) begin
      s4_d1   <= s3_d1;
      s4_low  <= s3_low;
      s4_aux  <= aux_full[33:0];
      s4_off  <= s3_off;
      s4_sens <= s3_sens;
      s4_temp <= TEMP_BASE + $signed({{2{s3_q[17]}}, s3_q}) - $signed({3'b0, s3_ti});
    end
  end

  // Stage 5: second-order offset and sensitivity terms.
  logic [35:0] aux3;
  logic [36:0] aux5;

  assign aux3 = {1'b0, s4_aux, 1'b0} + {2'b0, s4_aux};
  assign aux5 = {1'b0, s4_aux, 2'b0} + {3'b0, s4_aux};

  logic [RAW_W-1:0]         s5_d1;
  logic [34:0]              s5_offi;
  logic [33:0]              s5_sensi;
  logic signed [34:0]       s5_off;
  logic signed [33:0]       s5_sens;
  logic signed [TEMP_W-1:0] s5_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[4]) begin
      s5_d1    <= s4_d1;
      s5_offi  <= s4_low ? aux3[35:1] : {5'b0, s4_aux[33:4]};
      s5_sensi <= s4_low ? aux5[36:3] : 34'd0;
      s5_off   <= s4_off;
      s5_sens  <= s4_sens;
      s5_temp  <= s4_temp;
    end
  end

  // Stage 6: corrected OFF2 and SENS2.
  logic [RAW_W-1:0]         s6_d1;
  logic signed [36:0]       s6_off2;
  logic signed [34:0]       s6_sens2;
  logic signed [TEMP_W-1:0] s6_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[5]) begin
      s6_d1    <= s5_d1;
      s6_off2  <= $signed({{2{s5_off[34]}}, s5_off}) - $signed({2'b0, s5_offi});
      s6_sens2 <= $signed({s5_sens[33], s5_sens}) - $signed({1'b0, s5_sensi});
      s6_temp  <= s5_temp;
    end
  end

  // Stage 7: D1 * SENS2 as two partial products over the low and high halves.
  logic signed [16:0] sens2_hi;

  assign sens2_hi = s6_sens2[34:18];

  logic [41:0]              s7_pp_lo;
  logic signed [41:0]       s7_pp_hi;
  logic signed [36:0]       s7_off2;
  logic signed [TEMP_W-1:0] s7_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[6]) begin
      s7_pp_lo <= s6_d1 * s6_sens2[17:0];
      s7_pp_hi <= $signed({1'b0, s6_d1}) * sens2_hi;
      s7_off2  <= s6_off2;
      s7_temp  <= s6_temp;
    end
  end

  // Stage 8: combine the partial products.
  logic signed [59:0] prod_sum;

  assign prod_sum = $signed({s7_pp_hi, 18'b0}) + $signed({18'b0, s7_pp_lo});

  logic signed [58:0]       s8_prod;
  logic signed [36:0]       s8_off2;
  logic signed [TEMP_W-1:0] s8_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[7]) begin
      s8_prod <= prod_sum[58:0];
      s8_off2 <= s7_off2;
      s8_temp <= s7_temp;
    end
  end

  // Stage 9: truncating division of the product by 2^21.
  logic signed [58:0] p_sum;
  logic signed [58:0] p_quot;

  assign p_sum  = s8_prod + (s8_prod[58] ? 59'sd2097151 : 59'sd0);
  assign p_quot = p_sum >>> 21;

  logic signed [37:0]       s9_q2;
  logic signed [36:0]       s9_off2;
  logic signed [TEMP_W-1:0] s9_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[8]) begin
      s9_q2   <= p_quot[37:0];
      s9_off2 <= s8_off2;
      s9_temp <= s8_temp;
    end
  end

  // Stage 10: subtract the offset.
  logic signed [38:0]       s10_y;
  logic signed [TEMP_W-1:0] s10_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[9]) begin
      s10_y    <= $signed({s9_q2[37], s9_q2}) - $signed({{2{s9_off2[36]}}, s9_off2});
      s10_temp <= s9_temp;
    end
  end

  // Stage 11: range checks and the divide by 4096 * 10. A negative value
  // clamps to zero, so only the non-negative quotient is needed.
  logic [25:0] z;

  assign z = s10_y[37:12];

  logic                     s11_neg;
  logic                     s11_big;
  logic [52:0]              s11_zm;
  logic signed [TEMP_W-1:0] s11_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[10]) begin
      s11_neg  <= s10_y[38];
      s11_big  <= z >= P_SAT_Z;
      s11_zm   <= z * RECIP10;
      s11_temp <= s10_temp;
    end
  end

  // Stage 12: saturate and hold the result beat.
  logic [PRESS_W-1:0]       s12_press;
  logic signed [TEMP_W-1:0] s12_temp;

  always_ff @(posedge clk) begin
    if (pipe.en[11]) begin
      if (s11_neg) begin
        s12_press <= '0;
      end else if (s11_big) begin
        s12_press <= P_MAX;
      end else begin
        s12_press <= s11_zm[51:30];
      end
      s12_temp <= s11_temp;
    end
  end

  assign result.valid             = pipe.valid[PTC_STAGES-1];
  assign result.temperature_centi = s12_temp;
  assign result.pressure_value    = s12_press;

  // An accepted sample beat always lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> pipe.valid[0])
    else $error("accepted sample beat missing from first stage");

  // A full pipeline behind a stalled result must refuse new samples.
  assert property (@(posedge clk) disable iff (rst)
    (&pipe.valid) && !result.ready |-> !sample.ready)
    else $error("sample accepted while pipeline is full and stalled");

  // The second-order temperature term never exceeds its bound.
  assert property (@(posedge clk) disable iff (rst)
    pipe.valid[2] |-> s3_ti <= TI_MAX)
    else $error("second-order temperature term out of range");

endmodule
